[src/tirf_pkg.sv]
// Package with shared types, constants and byte tables of the telnet receive filter.
package tirf_pkg;

  localparam int NumSessionsDefault = 4;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);

  localparam logic [11:0] SubnegLimitReset = 12'd256;
  localparam logic [7:0] AcceptedOptionReset = 8'h03;

  localparam logic [7:0] TelIac  = 8'hFF;
  localparam logic [7:0] TelSb   = 8'hFA;
  localparam logic [7:0] TelSe   = 8'hF0;
  localparam logic [7:0] TelWill = 8'hFB;
  localparam logic [7:0] TelDo   = 8'hFD;
  localparam logic [7:0] TelDont = 8'hFE;
  localparam logic [7:0] TelEcho = 8'h01;
  localparam logic [7:0] TelSga  = 8'h03;
  localparam logic [7:0] TelEot  = 8'h04;

  localparam logic [1:0] CmdByte  = 2'd0;
  localparam logic [1:0] CmdOpen  = 2'd1;
  localparam logic [1:0] CmdClose = 2'd2;

  localparam logic RegSubnegLimit = 1'b0;
  localparam logic RegAcceptedOption = 1'b1;

  localparam logic DestConsole = 1'b0;
  localparam logic DestPeer = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] slot;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] out_slot;
    logic       dest;
    logic [7:0] out_byte;
    logic       end_session;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    PsData   = 3'd0,
    PsIac    = 3'd1,
    PsOption = 3'd2,
    PsSub    = 3'd3,
    PsSubIac = 3'd4
  } parse_e;

  typedef enum logic [1:0] {
    JobData  = 2'd0,
    JobGreet = 2'd1,
    JobBye   = 2'd2,
    JobReply = 2'd3
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic [1:0] slot;
    logic [7:0] data;
    logic       accept;
  } job_t;

  function automatic logic [7:0] greet_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = TelIac;
      3'd1: b = TelWill;
      3'd2: b = TelEcho;
      3'd3: b = TelIac;
      3'd4: b = TelWill;
      default: b = TelSga;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bye_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h0D;
      3'd1: b = 8'h0A;
      3'd2: b = 8'h1B;
      3'd3: b = 8'h5B;
      3'd4: b = 8'h30;
      default: b = 8'h6D;
    endcase
    return b;
  endfunction

endpackage

[src/tirf_front.sv]
// Front end: accepts session events, runs the per-session parser and issues output jobs.
module tirf_front #(
  parameter int NumSessions = tirf_pkg::NumSessionsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tirf_pkg::in_t    in_data_i,
  input  logic [11:0]      subneg_limit_i,
  input  logic [7:0]       accepted_option_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tirf_pkg::job_t   q_job_o
);
  import tirf_pkg::*;

  localparam int IdxW = (NumSessions > 1) ? $clog2(NumSessions) : 1;

  logic        open_q    [NumSessions];
  parse_e      state_q   [NumSessions];
  logic        will_q    [NumSessions];
  logic [12:0] count_q   [NumSessions];

  logic            accept;
  logic            slot_ok;
  logic [IdxW+1:0] slot_ext;
  logic [IdxW-1:0] idx;
  logic            upd;
  logic            open_d;
  parse_e          state_d;
  logic            will_d;
  logic [12:0]     count_d;
  logic [12:0]     count_inc;
  job_t            job;
  logic            push;
  logic [7:0]      b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_ext   = (IdxW + 2)'(in_data_i.slot);
  assign idx        = slot_ext[IdxW-1:0];
  assign slot_ok    = 32'(in_data_i.slot) < NumSessions;
  assign upd        = accept && slot_ok;
  assign b          = in_data_i.rx_byte;
  assign count_inc  = count_q[idx] + 13'd1;

  always_comb begin
    open_d  = open_q[idx];
    state_d = state_q[idx];
    will_d  = will_q[idx];
    count_d = count_q[idx];
    job     = '{kind: JobData, slot: in_data_i.slot, data: b, accept: 1'b0};
    push    = 1'b0;
    if (in_data_i.cmd == CmdOpen) begin
      open_d  = 1'b1;
      state_d = PsData;
      will_d  = 1'b0;
      count_d = '0;
      job.kind = JobGreet;
      push    = 1'b1;
    end else if (in_data_i.cmd == CmdClose) begin
      open_d  = 1'b0;
      state_d = PsData;
      will_d  = 1'b0;
      count_d = '0;
    end else if (in_data_i.cmd == CmdByte && open_q[idx]) begin
      unique case (state_q[idx])
        PsIac: begin
          if (b == TelIac) begin
            state_d = PsData;
            job.kind = JobData;
            push = 1'b1;
          end else if (b == TelSb) begin
            state_d = PsSub;
            count_d = '0;
          end else begin
            will_d  = (b == TelWill);
            state_d = PsOption;
          end
        end
        PsOption: begin
          if (will_q[idx]) begin
            job.kind   = JobReply;
            job.accept = (b == accepted_option_i);
            push       = 1'b1;
          end
          will_d  = 1'b0;
          state_d = PsData;
        end
        PsSub, PsSubIac: begin
          if (state_q[idx] == PsSub && b == TelIac) begin
            state_d = PsSubIac;
          end else if (state_q[idx] == PsSubIac && b == TelSe) begin
            state_d = PsData;
            count_d = '0;
          end else begin
            state_d = PsSub;
            count_d = count_inc;
            if (count_inc > {1'b0, subneg_limit_i}) begin
              state_d = PsData;
              count_d = '0;
            end
          end
        end
        default: begin
          state_d = PsData;
          if (b == TelIac) begin
            state_d = PsIac;
          end else if (b == TelEot) begin
            job.kind = JobBye;
            push    = 1'b1;
            open_d  = 1'b0;
            will_d  = 1'b0;
            count_d = '0;
          end else begin
            job.kind = JobData;
            push = 1'b1;
          end
        end
      endcase
    end
  end

  assign q_push_o = upd && push;
  assign q_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSessions; i++) begin
        open_q[i]  <= 1'b0;
        state_q[i] <= PsData;
        will_q[i]  <= 1'b0;
        count_q[i] <= '0;
      end
    end else if (upd) begin
      open_q[idx]  <= open_d;
      state_q[idx] <= state_d;
      will_q[idx]  <= will_d;
      count_q[idx] <= count_d;
    end
  end

endmodule

[src/tirf_queue.sv]
// Small job queue between the parser front end and the output sequencer.
module tirf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tirf_pkg::job_t  push_job_i,
  output logic            full_o,
  output logic            valid_o,
  output tirf_pkg::job_t  head_o,
  input  logic            pop_i
);
  import tirf_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q;
  logic [QueuePtrW-1:0] rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = cnt_q == (QueuePtrW + 1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/tirf_back.sv]
// Back end: expands each job into result transactions through an output register.
module tirf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  tirf_pkg::job_t  q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tirf_pkg::out_t  out_data_o
);
  import tirf_pkg::*;

  job_t       cur_q;
  logic       cur_valid_q;
  logic [2:0] idx_q;
  out_t       out_q;
  logic       out_valid_q;
  out_t       item;
  logic       item_last;
  logic       load;
  logic       pop;

  always_comb begin
    item = '{out_slot: cur_q.slot, dest: DestPeer, out_byte: cur_q.data,
             end_session: 1'b0, last: 1'b0};
    item_last = 1'b0;
    unique case (cur_q.kind)
      JobData: begin
        item.dest = DestConsole;
        item_last = 1'b1;
      end
      JobGreet: begin
        item.out_byte = greet_byte(idx_q);
        item_last = idx_q == 3'd5;
      end
      JobBye: begin
        item.out_byte = bye_byte(idx_q);
        item_last = idx_q == 3'd5;
        item.end_session = item_last;
      end
      JobReply: begin
        if (idx_q == 3'd0) begin
          item.out_byte = TelIac;
        end else if (idx_q == 3'd1) begin
          item.out_byte = cur_q.accept ? TelDo : TelDont;
        end
        item_last = idx_q == 3'd2;
      end
    endcase
    item.last = item_last;
  end

  assign load        = cur_valid_q && (!out_valid_q || out_ready_i);
  assign pop         = q_valid_i && (!cur_valid_q || (load && item_last));
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        cur_q <= q_head_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        cur_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (load && item_last) begin
        cur_valid_q <= 1'b0;
      end else if (load) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

[src/telnet_iac_receive_filter.sv]
// Top level of the telnet receive filter with its configuration registers.
//
//   Channel   Direction  Handshake          Payload
//   in        input      in_valid/in_ready  in_data_i  (cmd, slot, rx_byte)
//   out       output     out_valid/ready    out_data_o (out_slot, dest, out_byte, ...)
//   config    input      APB psel/penable   paddr, pwdata, prdata
//
// One event transaction is accepted per cycle while the four-entry job queue has room.
// With out_ready high, the output sequencer sends one result transaction per cycle:
// one for a data byte, three for an option reply and six for the greeting or the farewell.
// A job waits in the queue while the output is stalled, so input stalls only when it fills.
// Reset closes all sessions and restores the register defaults at once.
module telnet_iac_receive_filter #(
  parameter int NumSessions = tirf_pkg::NumSessionsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tirf_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tirf_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import tirf_pkg::*;

  logic [11:0] subneg_limit_q;
  logic [7:0]  accepted_option_q;
  logic        cfg_write;
  logic        q_full;
  logic        q_push;
  job_t        q_job;
  logic        q_valid;
  job_t        q_head;
  logic        q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == RegAcceptedOption) ? {24'd0, accepted_option_q}
                                                     : {20'd0, subneg_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subneg_limit_q    <= SubnegLimitReset;
      accepted_option_q <= AcceptedOptionReset;
    end else if (cfg_write) begin
      if (paddr[2] == RegSubnegLimit) begin
        subneg_limit_q <= pwdata[11:0];
      end else begin
        accepted_option_q <= pwdata[7:0];
      end
    end
  end

  tirf_front #(
    .NumSessions(NumSessions)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .subneg_limit_i    (subneg_limit_q),
    .accepted_option_i (accepted_option_q),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_job_o           (q_job)
  );

  tirf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  tirf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench that drives session events into the telnet receive filter.
module testbench;
  import tirf_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int NumSess = NumSessionsDefault;
  localparam int DrainCycles = 24;
  localparam int LongHold = 300;
  localparam int TimeoutCycles = 400000;
  localparam int RandomPerPhase = 100;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [7:0] TelWont = 8'hFC;
  localparam logic [47:0] GreetSeq = {TelIac, TelWill, TelEcho, TelIac, TelWill, TelSga};
  localparam logic [47:0] ByeSeq = 48'h0D0A_1B5B_306D;

  typedef struct packed {
    in_t  ev;
    logic typed;
    logic has_res;
    out_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        sess_open [NumSess];
  parse_e      parse_st [NumSess];
  logic        will_pend [NumSess];
  logic [12:0] sub_cnt [NumSess];
  logic [11:0] cfg_limit;
  logic [7:0]  cfg_option;

  out_t        event_out [6];
  int          event_out_n;
  out_t        filter_out_q [$];
  out_t        head_res;
  row_t        directed_rows [$];
  in_t         seq_q [$];
  int          err_count = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          rx_cycle = 0;
  int          hold_req_cnt = 0;
  int          hold_seen = 0;

  telnet_iac_receive_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic add_out(input logic [1:0] slot, input logic dest, input logic [7:0] b,
                         input logic ends);
    out_t r;
    r.out_slot = slot;
    r.dest = dest;
    r.out_byte = b;
    r.end_session = ends;
    r.last = 1'b0;
    event_out[event_out_n] = r;
    event_out_n++;
  endtask

  task automatic clear_parser(input int s);
    parse_st[s] = PsData;
    will_pend[s] = 1'b0;
    sub_cnt[s] = '0;
  endtask

  task automatic count_sub(input int s);
    sub_cnt[s] = sub_cnt[s] + 13'd1;
    if (sub_cnt[s] > {1'b0, cfg_limit}) begin
      parse_st[s] = PsData;
      sub_cnt[s] = '0;
    end
  endtask

  task automatic filter_event(input in_t ev);
    int s;
    logic [7:0] b;
    s = int'(ev.slot);
    b = ev.rx_byte;
    event_out_n = 0;
    if (ev.cmd == CmdOpen) begin
      sess_open[s] = 1'b1;
      clear_parser(s);
      for (int i = 0; i < 6; i++) add_out(ev.slot, DestPeer, GreetSeq[47 - 8 * i -: 8], 1'b0);
    end else if (ev.cmd == CmdClose) begin
      sess_open[s] = 1'b0;
      clear_parser(s);
    end else if (ev.cmd == CmdByte && sess_open[s]) begin
      case (parse_st[s])
        PsIac: begin
          if (b == TelIac) begin
            parse_st[s] = PsData;
            add_out(ev.slot, DestConsole, TelIac, 1'b0);
          end else if (b == TelSb) begin
            parse_st[s] = PsSub;
            sub_cnt[s] = '0;
          end else begin
            will_pend[s] = (b == TelWill);
            parse_st[s] = PsOption;
          end
        end
        PsOption: begin
          if (will_pend[s]) begin
            add_out(ev.slot, DestPeer, TelIac, 1'b0);
            add_out(ev.slot, DestPeer, (b == cfg_option) ? TelDo : TelDont, 1'b0);
            add_out(ev.slot, DestPeer, b, 1'b0);
          end
          will_pend[s] = 1'b0;
          parse_st[s] = PsData;
        end
        PsSub: begin
          if (b == TelIac) parse_st[s] = PsSubIac;
          else count_sub(s);
        end
        PsSubIac: begin
          if (b == TelSe) begin
            parse_st[s] = PsData;
            sub_cnt[s] = '0;
          end else begin
            parse_st[s] = PsSub;
            count_sub(s);
          end
        end
        default: begin
          parse_st[s] = PsData;
          if (b == TelIac) begin
            parse_st[s] = PsIac;
          end else if (b == TelEot) begin
            for (int i = 0; i < 6; i++) begin
              add_out(ev.slot, DestPeer, ByeSeq[47 - 8 * i -: 8], i == 5);
            end
            sess_open[s] = 1'b0;
            clear_parser(s);
          end else begin
            add_out(ev.slot, DestConsole, b, 1'b0);
          end
        end
      endcase
    end
  endtask

  task automatic send_item(input in_t ev, input logic typed, input logic has_res,
                           input out_t res);
    out_t r;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    burst_left--;
    do @(posedge clk_i); while (!in_ready_o);
    filter_event(ev);
    if (typed) begin
      if (has_res) filter_out_q.push_back(res);
    end else begin
      for (int i = 0; i < event_out_n; i++) begin
        r = event_out[i];
        r.last = (i == event_out_n - 1);
        filter_out_q.push_back(r);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (filter_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic regsel, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (regsel == RegSubnegLimit) ? 32'hFFF : 32'hFF;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (val & mask)) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, regsel,
               val & mask, rd & mask);
      err_count++;
    end
    if (regsel == RegSubnegLimit) cfg_limit = val[11:0];
    else cfg_option = val[7:0];
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic [1:0] slot, input logic [7:0] b,
                         input logic typed, input logic has_res, input logic dest,
                         input logic [7:0] ob);
    row_t row;
    row.ev.cmd = cmd;
    row.ev.slot = slot;
    row.ev.rx_byte = b;
    row.typed = typed;
    row.has_res = has_res;
    row.res.out_slot = slot;
    row.res.dest = dest;
    row.res.out_byte = ob;
    row.res.end_session = 1'b0;
    row.res.last = 1'b1;
    directed_rows.push_back(row);
  endtask

  task automatic push_ev(input logic [1:0] cmd, input logic [1:0] slot, input logic [7:0] b);
    in_t ev;
    ev.cmd = cmd;
    ev.slot = slot;
    ev.rx_byte = b;
    seq_q.push_back(ev);
  endtask

  task automatic build_sequence(input logic [1:0] s);
    int kind;
    int n;
    logic [7:0] b;
    seq_q.delete();
    kind = $urandom_range(0, 99);
    if (!sess_open[s]) begin
      if (kind < 90) push_ev(CmdOpen, s, 8'($urandom_range(0, 255)));
      else push_ev(CmdByte, s, 8'($urandom_range(0, 255)));
    end else if (kind < 35) begin
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == TelIac || b == TelEot) b = b ^ 8'h10;
        push_ev(CmdByte, s, b);
      end
    end else if (kind < 45) begin
      push_ev(CmdByte, s, TelIac);
      push_ev(CmdByte, s, TelIac);
    end else if (kind < 60) begin
      push_ev(CmdByte, s, TelIac);
      push_ev(CmdByte, s, TelWill);
      push_ev(CmdByte, s, $urandom_range(0, 1) ? cfg_option : 8'($urandom_range(0, 255)));
    end else if (kind < 68) begin
      n = $urandom_range(0, 3);
      push_ev(CmdByte, s, TelIac);
      push_ev(CmdByte, s, (n == 0) ? TelDo : (n == 1) ? TelDont : (n == 2) ? TelWont :
              8'($urandom_range(0, 255)));
      push_ev(CmdByte, s, 8'($urandom_range(0, 255)));
    end else if (kind < 80) begin
      push_ev(CmdByte, s, TelIac);
      push_ev(CmdByte, s, TelSb);
      n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        push_ev(CmdByte, s, b);
        if (b == TelIac) begin
          push_ev(CmdByte, s, ($urandom_range(0, 3) != 0) ? TelIac : 8'($urandom_range(0, 255)));
        end
      end
      push_ev(CmdByte, s, TelIac);
      push_ev(CmdByte, s, TelSe);
    end else if (kind < 85) begin
      push_ev(CmdByte, s, TelEot);
    end else if (kind < 89) begin
      push_ev(CmdClose, s, 8'($urandom_range(0, 255)));
    end else if (kind < 92) begin
      push_ev(CmdOpen, s, 8'($urandom_range(0, 255)));
    end else if (kind < 97) begin
      push_ev(CmdByte, s, 8'($urandom_range(0, 255)));
    end else begin
      push_ev(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int useful;
    in_t ev;
    out_t none;
    useful = 0;
    none = '0;
    while (useful < count) begin
      build_sequence(2'($urandom_range(0, NumSess - 1)));
      while (seq_q.size() != 0) begin
        ev = seq_q.pop_front();
        if (ev.cmd != CmdUnused && (ev.cmd != CmdByte || sess_open[ev.slot])) useful++;
        send_item(ev, 1'b0, 1'b0, none);
      end
    end
  endtask

  task automatic report_field(input string name, input int expv, input int gotv);
    if (expv != gotv) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, expv, gotv);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filter_out_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, out_data_o);
        err_count++;
      end else begin
        head_res = filter_out_q.pop_front();
        if (out_data_o !== head_res) begin
          err_count++;
          report_field("out_slot", head_res.out_slot, out_data_o.out_slot);
          report_field("dest", head_res.dest, out_data_o.dest);
          report_field("out_byte", head_res.out_byte, out_data_o.out_byte);
          report_field("end_session", head_res.end_session, out_data_o.end_session);
          report_field("last", head_res.last, out_data_o.last);
          if ($isunknown(out_data_o)) begin
            $display("%0t: result expected %h actual %h", $time, head_res, out_data_o);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req_cnt != hold_seen) begin
      hold_left = LongHold;
      hold_seen = hold_req_cnt;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (rx_cycle % 3 == 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_limit = SubnegLimitReset;
    cfg_option = AcceptedOptionReset;
    for (int i = 0; i < NumSess; i++) begin
      sess_open[i] = 1'b0;
      clear_parser(i);
    end

    add_row(CmdByte, 2'd0, 8'h41, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdClose, 2'd1, 8'h00, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdUnused, 2'd2, 8'hFF, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdOpen, 2'd0, 8'h00, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, 8'h00, 1'b1, 1'b1, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, 8'hFE, 1'b1, 1'b1, DestConsole, 8'hFE);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b1, DestConsole, TelIac);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelWill, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelSga, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelWill, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, 8'hFF, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelDo, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelEcho, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelSb, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, 8'h18, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelIac, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd0, TelSe, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdOpen, 2'd3, 8'h00, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdOpen, 2'd3, 8'hFF, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd3, TelEot, 1'b0, 1'b0, DestConsole, 8'h00);
    add_row(CmdByte, 2'd3, 8'h41, 1'b1, 1'b0, DestConsole, 8'h00);
    add_row(CmdClose, 2'd0, 8'h00, 1'b1, 1'b0, DestConsole, 8'h00);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].has_res,
                directed_rows[i].res);
    end
    run_random(RandomPerPhase);
    wait_idle();

    cfg_write(RegSubnegLimit, 32'd0);
    cfg_write(RegAcceptedOption, 32'd0);
    run_random(RandomPerPhase);
    wait_idle();

    cfg_write(RegSubnegLimit, 32'hFFFF_FFFF);
    cfg_write(RegAcceptedOption, 32'hFFFF_FFFF);
    run_random(RandomPerPhase);
    wait_idle();

    cfg_write(RegSubnegLimit, 32'd3);
    cfg_write(RegAcceptedOption, {24'd0, TelEcho});
    hold_req_cnt++;
    run_random(RandomPerPhase);
    wait_idle();

    cfg_write(RegSubnegLimit, $urandom_range(0, 12));
    cfg_write(RegAcceptedOption, $urandom);
    hold_req_cnt++;
    run_random(RandomPerPhase);
    wait_idle();

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
src/tirf_pkg.sv
src/tirf_front.sv
src/tirf_queue.sv
src/tirf_back.sv
src/telnet_iac_receive_filter.sv
verif/testbench.sv
